[sv/cprd_pkg.sv]
// ----------------------------------------------------------------------------
// cprd_pkg
// shared constants and types of the primary ray direction block
// ----------------------------------------------------------------------------
package cprd_pkg;

  localparam int unsigned BASIS_WIDTH_DEF     = 21;
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;

  localparam int unsigned NUM_COMP    = 3;
  localparam int unsigned CFG_W       = 63;
  localparam int unsigned APB_DW      = 64;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned OUT_FRAC    = 15;
  localparam int unsigned MAG_W       = 30;
  localparam int unsigned SUM_W       = 2 * MAG_W + 2;
  localparam int unsigned ROOT_W      = MAG_W + 1;
  localparam int unsigned SQRT_STEPS  = ROOT_W;
  localparam int unsigned NUM_W       = ROOT_W + OUT_FRAC;
  localparam int unsigned Q_W         = OUT_FRAC + 1;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register index codes, taken from paddr above the 8 byte offset
  localparam logic [1:0] REG_FORWARD = 2'd0;
  localparam logic [1:0] REG_RIGHT   = 2'd1;
  localparam logic [1:0] REG_UP      = 2'd2;

  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32767);
  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32768);

  typedef struct packed {
    logic [CFG_W-1:0] up;
    logic [CFG_W-1:0] right;
    logic [CFG_W-1:0] forward;
  } basis_cfg_t;

  typedef struct packed {
    logic [NUM_COMP-1:0][MAG_W-1:0] mag;
    logic [NUM_COMP-1:0]            neg;
    logic                           zero;
  } norm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/cprd_in_if.sv]
// ----------------------------------------------------------------------------
// cprd_in_if
// request channel carrying one image coordinate pair
// ----------------------------------------------------------------------------
interface cprd_in_if #(
  parameter int unsigned COORD_W = cprd_pkg::COORD_FRAC_BITS_DEF + 1
);
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] image_x;
  logic [COORD_W-1:0] image_y;

  modport source (output valid, image_x, image_y, input ready);
  modport sink   (input valid, image_x, image_y, output ready);
endinterface

[sv/cprd_out_if.sv]
// ----------------------------------------------------------------------------
// cprd_out_if
// result channel carrying one unit ray direction
// ----------------------------------------------------------------------------
interface cprd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cprd_pkg::OUT_W-1:0]   dir_x;
  logic signed [cprd_pkg::OUT_W-1:0]   dir_y;
  logic signed [cprd_pkg::OUT_W-1:0]   dir_z;
  logic                                zero_length;

  modport source (output valid, dir_x, dir_y, dir_z, zero_length, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, zero_length, output ready);
endinterface

[sv/cprd_regs.sv]
// ----------------------------------------------------------------------------
// cprd_regs
// apb register file holding the three camera basis vectors
// ----------------------------------------------------------------------------
module cprd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cprd_pkg::APB_AW-1:0]   paddr,
  input  logic [cprd_pkg::APB_DW-1:0]   pwdata,
  output logic [cprd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output cprd_pkg::basis_cfg_t          cfg_o
);
  import cprd_pkg::*;

  logic [CFG_W-1:0] fwd_q, rgt_q, up_q;
  logic             wr;
  logic [1:0]       idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[APB_AW-1:3];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rgt_q <= '0;
      up_q  <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_FORWARD: fwd_q <= pwdata[CFG_W-1:0];
        REG_RIGHT:   rgt_q <= pwdata[CFG_W-1:0];
        REG_UP:      up_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORWARD: prdata = APB_DW'(fwd_q);
      REG_RIGHT:   prdata = APB_DW'(rgt_q);
      REG_UP:      prdata = APB_DW'(up_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.forward = fwd_q;
  assign cfg_o.right   = rgt_q;
  assign cfg_o.up      = up_q;

endmodule

[sv/cprd_front.sv]
// ----------------------------------------------------------------------------
// cprd_front
// forms the raw direction, flags zero length and normalizes magnitudes
// ----------------------------------------------------------------------------
module cprd_front #(
  parameter int unsigned BASIS_WIDTH     = cprd_pkg::BASIS_WIDTH_DEF,
  parameter int unsigned COORD_FRAC_BITS = cprd_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cprd_in_if.sink                   req,
  input  cprd_pkg::basis_cfg_t      cfg_i,
  input  cprd_pkg::queue_status_t   q_stat_i,
  output logic                      push_o,
  output cprd_pkg::norm_item_t      item_o
);
  import cprd_pkg::*;

  localparam int unsigned BW    = BASIS_WIDTH;
  localparam int unsigned CF    = COORD_FRAC_BITS;
  localparam int unsigned CW    = CF + 1;
  localparam int unsigned PW    = BW + CW + 1;
  localparam int unsigned MIW   = BW + CF + 3;
  localparam int unsigned DW    = MIW + 1;
  localparam int unsigned CHUNK = 8;
  localparam int unsigned NCH   = (MIW + CHUNK - 1) / CHUNK;
  localparam int unsigned PADW  = NCH * CHUNK;
  localparam int unsigned POS_W = $clog2(PADW);
  localparam int unsigned EXT_W = MIW + MAG_W - 1;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic signed [BW-1:0] f_c [NUM_COMP];
  logic signed [BW-1:0] r_c [NUM_COMP];
  logic signed [BW-1:0] u_c [NUM_COMP];

  logic signed [PW-1:0]   xr_q   [NUM_COMP];
  logic signed [PW-1:0]   yu_q   [NUM_COMP];
  logic signed [BW+1:0]   base_q [NUM_COMP];
  logic signed [DW-1:0]   d_q    [NUM_COMP];
  logic [MIW-1:0]         mag3_q [NUM_COMP];
  logic [MIW-1:0]         mag4_q [NUM_COMP];
  logic [MIW-1:0]         mag5_q [NUM_COMP];
  logic [NUM_COMP-1:0]    neg3_q, neg4_q, neg5_q;
  logic                   zero3_q, zero4_q, zero5_q;
  logic [MIW-1:0]         or_q;
  logic [PADW-1:0]        pad;
  logic [NCH-1:0]         any_d, any_q;
  logic [NCH-1:0][2:0]    loc_d, loc_q;
  logic [POS_W-1:0]       p_d, p_q;
  norm_item_t             item_d, item_q;

  // whole front moves together; stalls only when its last stage cannot push
  assign en        = !v6_q || !q_stat_i.full;
  assign req.ready = en;
  assign push_o    = v6_q && en;
  assign item_o    = item_q;

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_comp
    assign f_c[k] = $signed(cfg_i.forward[k*BW +: BW]);
    assign r_c[k] = $signed(cfg_i.right[k*BW +: BW]);
    assign u_c[k] = $signed(cfg_i.up[k*BW +: BW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= req.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // coordinate products and constant term
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        xr_q[k]   <= $signed({1'b0, req.image_x}) * r_c[k];
        yu_q[k]   <= $signed({1'b0, req.image_y}) * u_c[k];
        base_q[k] <= (BW+2)'(f_c[k]) + (BW+2)'(u_c[k]) - (BW+2)'(r_c[k]);
      end
    end
  end

  // raw direction
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        d_q[k] <= (DW'(base_q[k]) <<< CF) + (DW'(xr_q[k]) <<< 1) - (DW'(yu_q[k]) <<< 1);
      end
    end
  end

  // sign, magnitude and zero check
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        neg3_q[k] <= d_q[k][DW-1];
        mag3_q[k] <= d_q[k][DW-1] ? MIW'(-d_q[k]) : MIW'(d_q[k]);
      end
      zero3_q <= (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);
      or_q    <= (d_q[0][DW-1] ? MIW'(-d_q[0]) : MIW'(d_q[0]))
               | (d_q[1][DW-1] ? MIW'(-d_q[1]) : MIW'(d_q[1]))
               | (d_q[2][DW-1] ? MIW'(-d_q[2]) : MIW'(d_q[2]));
    end
  end

  // leading one per byte of the or of magnitudes
  always_comb begin
    pad   = PADW'(or_q);
    any_d = '0;
    loc_d = '0;
    for (int c = 0; c < NCH; c++) begin
      for (int b = 0; b < CHUNK; b++) begin
        if (pad[c*CHUNK+b]) begin
          any_d[c] = 1'b1;
          loc_d[c] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      any_q   <= any_d;
      loc_q   <= loc_d;
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // highest byte with a one wins
  always_comb begin
    p_d = '0;
    for (int c = 0; c < NCH; c++) begin
      if (any_q[c]) begin
        p_d = POS_W'(c * CHUNK) + POS_W'(loc_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q     <= p_d;
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // place the leading one at bit MAG_W-1, truncating below
  always_comb begin
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sh;
    ext    = '0;
    sh     = '0;
    item_d = '0;
    for (int k = 0; k < NUM_COMP; k++) begin
      ext            = {mag5_q[k], {(MAG_W-1){1'b0}}};
      sh             = ext >> p_q;
      item_d.mag[k]  = sh[MAG_W-1:0];
    end
    item_d.neg  = neg5_q;
    item_d.zero = zero5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q <= item_d;
    end
  end

endmodule

[sv/cprd_queue.sv]
// ----------------------------------------------------------------------------
// cprd_queue
// short queue between the front and the back
// ----------------------------------------------------------------------------
module cprd_queue #(
  parameter int unsigned DEPTH = cprd_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cprd_pkg::norm_item_t     item_i,
  input  logic                     pop_i,
  output cprd_pkg::norm_item_t     item_o,
  output cprd_pkg::queue_status_t  stat_o
);
  import cprd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  norm_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign item_o       = mem[rd_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

[sv/cprd_back.sv]
// ----------------------------------------------------------------------------
// cprd_back
// squared length, pipelined square root and per-lane division, saturation
// ----------------------------------------------------------------------------
module cprd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cprd_pkg::norm_item_t     item_i,
  input  cprd_pkg::queue_status_t  stat_i,
  output logic                     pop_o,
  cprd_out_if.source               rsp
);
  import cprd_pkg::*;

  typedef struct packed {
    logic [NUM_COMP-1:0] neg;
    logic                zero;
  } flags_t;

  logic en;

  norm_item_t           it0_q, it1_q;
  logic                 v0_q, v1_q;
  logic [2*MAG_W-1:0]   sq_q [NUM_COMP];

  logic [SUM_W-1:0]     sv_q [SQRT_STEPS+1];
  logic [SUM_W-1:0]     sr_q [SQRT_STEPS+1];
  logic                 vs_q [SQRT_STEPS+1];
  flags_t               fs_q [SQRT_STEPS+1];
  logic [NUM_COMP-1:0][MAG_W-1:0] ms_q [SQRT_STEPS+1];

  logic [NUM_COMP-1:0][NUM_W-1:0] rem_q [Q_W+1];
  logic [NUM_COMP-1:0][Q_W-1:0]   qt_q  [Q_W+1];
  logic [ROOT_W-1:0]              rt_q  [Q_W+1];
  logic                           vd_q  [Q_W+1];
  flags_t                         fd_q  [Q_W+1];

  logic                     out_v_q;
  logic signed [OUT_W-1:0]  dir_q [NUM_COMP];
  logic                     zl_q;
  logic [ROOT_W-1:0]        root;

  // the back stalls only on the result side
  assign en        = !out_v_q || rsp.ready;
  assign pop_o     = en && !stat_i.empty;
  assign rsp.valid = out_v_q;
  assign rsp.dir_x = dir_q[0];
  assign rsp.dir_y = dir_q[1];
  assign rsp.dir_z = dir_q[2];
  assign rsp.zero_length = zl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      vs_q[0]  <= 1'b0;
      vd_q[0]  <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (en) begin
      v0_q     <= pop_o;
      v1_q     <= v0_q;
      vs_q[0]  <= v1_q;
      vd_q[0]  <= vs_q[SQRT_STEPS];
      out_v_q  <= vd_q[Q_W];
    end
  end

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q <= item_i;
      for (int k = 0; k < NUM_COMP; k++) begin
        sq_q[k] <= it0_q.mag[k] * it0_q.mag[k];
      end
      it1_q      <= it0_q;
      sv_q[0]    <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      sr_q[0]    <= '0;
      fs_q[0]    <= {it1_q.neg, it1_q.zero};
      ms_q[0]    <= it1_q.mag;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SUM_W-1:0] trial;
    assign trial = sr_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j+1] <= 1'b0;
      end else if (en) begin
        vs_q[j+1] <= vs_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sv_q[j] >= trial) begin
          sv_q[j+1] <= sv_q[j] - trial;
          sr_q[j+1] <= (sr_q[j] >> 1) + BIT;
        end else begin
          sv_q[j+1] <= sv_q[j];
          sr_q[j+1] <= sr_q[j] >> 1;
        end
        fs_q[j+1] <= fs_q[j];
        ms_q[j+1] <= ms_q[j];
      end
    end
  end

  assign root = sr_q[SQRT_STEPS][ROOT_W-1:0];

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        rem_q[0][k] <= (NUM_W'(ms_q[SQRT_STEPS][k]) << OUT_FRAC) + NUM_W'(root >> 1);
      end
      qt_q[0] <= '0;
      rt_q[0] <= root;
      fd_q[0] <= fs_q[SQRT_STEPS];
    end
  end

  // restoring division, three lanes sharing the divisor
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int unsigned SH = Q_W - 1 - j;
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(rt_q[j]) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (en) begin
        vd_q[j+1] <= vd_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < NUM_COMP; k++) begin
          if (rem_q[j][k] >= dsh) begin
            rem_q[j+1][k]    <= rem_q[j][k] - dsh;
            qt_q[j+1][k]     <= qt_q[j][k] | (Q_W'(1) << SH);
          end else begin
            rem_q[j+1][k]    <= rem_q[j][k];
            qt_q[j+1][k]     <= qt_q[j][k];
          end
        end
        rt_q[j+1] <= rt_q[j];
        fd_q[j+1] <= fd_q[j];
      end
    end
  end

  // saturation, sign and zero length
  always_ff @(posedge clk_i) begin
    if (en) begin
      zl_q <= fd_q[Q_W].zero;
      for (int k = 0; k < NUM_COMP; k++) begin
        if (fd_q[Q_W].zero) begin
          dir_q[k] <= '0;
        end else if (fd_q[Q_W].neg[k]) begin
          dir_q[k] <= $signed(-((qt_q[Q_W][k] > NEG_LIMIT) ? NEG_LIMIT : qt_q[Q_W][k]));
        end else begin
          dir_q[k] <= $signed((qt_q[Q_W][k] > POS_LIMIT) ? POS_LIMIT : qt_q[Q_W][k]);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && zl_q) |-> (dir_q[0] == '0 && dir_q[1] == '0 && dir_q[2] == '0))
    else $error("zero length result with nonzero direction");
`endif

endmodule

[sv/camera_primary_ray_direction.sv]
// ----------------------------------------------------------------------------
// camera_primary_ray_direction
// throughput: one request per cycle while the result side does not stall,
// set by the fully pipelined root and divide
// the square root takes 31 stages and the per-lane divide 16 stages
// reset: asynchronous active low, clears all valids and the basis registers
// ----------------------------------------------------------------------------
module camera_primary_ray_direction #(
  parameter int unsigned BASIS_WIDTH     = cprd_pkg::BASIS_WIDTH_DEF,
  parameter int unsigned COORD_FRAC_BITS = cprd_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cprd_in_if.sink                       req_i,
  cprd_out_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cprd_pkg::APB_AW-1:0]   paddr,
  input  logic [cprd_pkg::APB_DW-1:0]   pwdata,
  output logic [cprd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import cprd_pkg::*;

  // basis vectors, written by the user only while the block is idle, unenforced
  basis_cfg_t     cfg;
  // front to queue
  logic           push;
  norm_item_t     push_item;
  // queue to back
  logic           pop;
  norm_item_t     pop_item;
  queue_status_t  q_stat;

  cprd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: products, raw direction, zero check and normalizing shift
  cprd_front #(
    .BASIS_WIDTH     (BASIS_WIDTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  // short queue so front and back can stall on their own
  cprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  // back: length, reciprocal scaling and saturation into the result register
  cprd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (pop_item),
    .stat_i (q_stat),
    .pop_o  (pop),
    .rsp    (rsp_o)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks camera_primary_ray_direction against a bit-true ray direction
// predictor, with directed rows, random basis settings and random stalls
// ----------------------------------------------------------------------------
module testbench;
  import cprd_pkg::*;

  localparam int unsigned CW         = 21;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned NORM_HIGH  = 30;
  localparam int unsigned SETTLE_CYC = 80;
  localparam int unsigned CYCLE_CAP  = 300000;

  typedef struct {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    zero_length;
  } ray_dir_t;

  // one directed row: basis set, coordinate pair, and a typed result if obvious
  typedef struct {
    int               basis_set;
    logic [COORD_W-1:0] image_x;
    logic [COORD_W-1:0] image_y;
    bit               typed;
    ray_dir_t         want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  cprd_in_if  req_if ();
  cprd_out_if rsp_if ();

  camera_primary_ray_direction dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the basis registers
  logic [CFG_W-1:0] forward_shadow = '0;
  logic [CFG_W-1:0] right_shadow = '0;
  logic [CFG_W-1:0] up_shadow = '0;

  ray_dir_t expected_dirs[$];
  int  mismatches = 0;
  int  rays_sent = 0;
  int  rays_checked = 0;
  int  zero_rays = 0;
  int  basis_writes = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  cycles = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_dirs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint basis_comp(logic [CFG_W-1:0] v, int k);
    logic signed [CW-1:0] c;
    c = v[k*CW +: CW];
    return longint'(c);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit direction through image point (x, y) for the current basis
  function automatic ray_dir_t trace_direction(logic [COORD_W-1:0] ix,
                                               logic [COORD_W-1:0] iy);
    ray_dir_t        r;
    longint          x, y, f, rt, u, d;
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned top, sum, root, q;
    logic [OUT_W-1:0] lane[3];
    x = longint'(ix);
    y = longint'(iy);
    top = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      f  = basis_comp(forward_shadow, k);
      rt = basis_comp(right_shadow, k);
      u  = basis_comp(up_shadow, k);
      d  = (f + u - rt) * 65536 + 2 * x * rt - 2 * y * u;
      neg[k] = d < 0;
      mag[k] = neg[k] ? longint'(-d) : longint'(d);
      if (mag[k] > top) top = mag[k];
    end
    if (top == 0) begin
      r = '{dir_x: '0, dir_y: '0, dir_z: '0, zero_length: 1'b1};
      return r;
    end
    // bring the largest magnitude into [2^29, 2^30)
    while (top >= (64'd1 << NORM_HIGH)) begin
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      top = top >> 1;
    end
    while (top < (64'd1 << (NORM_HIGH - 1))) begin
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
      top = top << 1;
    end
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    root = root_floor(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << OUT_FRAC) + (root >> 1)) / root;
      if (neg[k]) begin
        if (q > 32768) q = 32768;
        lane[k] = OUT_W'(-q);
      end else begin
        if (q > 32767) q = 32767;
        lane[k] = OUT_W'(q);
      end
    end
    r.dir_x = lane[0];
    r.dir_y = lane[1];
    r.dir_z = lane[2];
    r.zero_length = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    ray_dir_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_dirs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d zl=%0b", rsp_if.dir_x,
                   rsp_if.dir_y, rsp_if.dir_z, rsp_if.zero_length);
      end else begin
        want = expected_dirs.pop_front();
        rays_checked++;
        if (want.zero_length) zero_rays++;
        if (rsp_if.dir_x !== want.dir_x || rsp_if.dir_y !== want.dir_y ||
            rsp_if.dir_z !== want.dir_z || rsp_if.zero_length !== want.zero_length)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected (%0d,%0d,%0d,zl=%0b) got (%0d,%0d,%0d,zl=%0b)",
                     rays_checked, want.dir_x, want.dir_y, want.dir_z,
                     want.zero_length, rsp_if.dir_x, rsp_if.dir_y, rsp_if.dir_z,
                     rsp_if.zero_length);
        end
      end
    end
  end

  // receiver side: random ready, long hold-off on demand
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready = 1'b0;
    end else begin
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic [COORD_W-1:0] ix, logic [COORD_W-1:0] iy,
                              bit typed, ray_dir_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid   = 1'b1;
    req_if.image_x = ix;
    req_if.image_y = iy;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_dirs.push_back(typed ? want : trace_direction(ix, iy));
    rays_sent++;
    @(negedge clk);
  endtask

  // wait until every request has come back, then let the pipe settle
  task automatic drain_pipe();
    req_if.valid = 1'b0;
    while (expected_dirs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // two-phase register write, called at a falling edge
  task automatic write_basis(logic [1:0] idx, logic [APB_DW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'({idx, 3'b000});
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FORWARD: forward_shadow = val[CFG_W-1:0];
      REG_RIGHT:   right_shadow   = val[CFG_W-1:0];
      default:     up_shadow      = val[CFG_W-1:0];
    endcase
    basis_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_basis(logic [APB_DW-1:0] f, logic [APB_DW-1:0] r,
                            logic [APB_DW-1:0] u);
    drain_pipe();
    write_basis(REG_FORWARD, f);
    write_basis(REG_RIGHT, r);
    write_basis(REG_UP, u);
  endtask

  function automatic logic [APB_DW-1:0] pack_basis(logic [CW-1:0] cx,
                                                   logic [CW-1:0] cy,
                                                   logic [CW-1:0] cz);
    return {1'b0, cz, cy, cx};
  endfunction

  // random component: mostly anything, sometimes a range limit or zero
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(9))
      0:       return 21'h0FFFFF;
      1:       return 21'h100000;
      2:       return '0;
      3:       return CW'($urandom_range(65536)) - 21'd32768;
      default: return CW'($urandom);
    endcase
  endfunction

  // random coordinate: mostly inside the image, sometimes beyond it
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'(32768);
      default: return COORD_W'($urandom_range(65536));
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  localparam logic [CW-1:0] ONE_P  = 21'h008000;
  localparam logic [CW-1:0] ONE_N  = 21'h1F8000;
  localparam logic [CW-1:0] TOP_P  = 21'h0FFFFF;
  localparam logic [CW-1:0] TOP_N  = 21'h100000;

  initial begin
    logic [APB_DW-1:0] basis_sets[5][3];
    dir_row_t          rows[$];
    ray_dir_t          zl_dir, none;
    int                cur_set;
    int                n_items;
    logic [APB_DW-1:0] fv, rv, uv;

    req_if.valid   = 1'b0;
    req_if.image_x = '0;
    req_if.image_y = '0;
    rsp_if.ready   = 1'b0;

    zl_dir = '{dir_x: '0, dir_y: '0, dir_z: '0, zero_length: 1'b1};
    none   = '{dir_x: '0, dir_y: '0, dir_z: '0, zero_length: 1'b0};

    // set 0 is the reset state; set 1 a looking-down-minus-z camera;
    // set 2 range extremes; set 3 cancels at mid x; set 4 pure +x forward
    basis_sets[0] = '{64'd0, 64'd0, 64'd0};
    basis_sets[1] = '{pack_basis(0, 0, ONE_N), pack_basis(ONE_P, 0, 0),
                      pack_basis(0, ONE_P, 0)};
    basis_sets[2] = '{pack_basis(TOP_P, TOP_P, TOP_P) | 64'h8000_0000_0000_0000,
                      pack_basis(TOP_N, TOP_N, TOP_N),
                      pack_basis(TOP_P, TOP_N, TOP_P)};
    basis_sets[3] = '{64'd0, pack_basis(21'd5, -21'sd7, 21'd100), 64'd0};
    basis_sets[4] = '{pack_basis(ONE_P, 0, 0), 64'd0, 64'd0};

    // after reset every basis is zero, so every ray has zero length
    rows.push_back('{0, 17'd0,      17'd0,      1, zl_dir});
    rows.push_back('{0, 17'h1FFFF,  17'h1FFFF,  1, zl_dir});
    rows.push_back('{0, 17'd65536,  17'd0,      1, zl_dir});
    // image center looks straight down the forward axis, giving -1.0 at the low limit
    rows.push_back('{1, 17'd32768,  17'd32768,  1,
                     '{dir_x: 0, dir_y: 0, dir_z: -16'sd32768, zero_length: 0}});
    rows.push_back('{1, 17'd0,      17'd0,      0, none});
    rows.push_back('{1, 17'd65536,  17'd65536,  0, none});
    rows.push_back('{1, 17'd0,      17'd65536,  0, none});
    rows.push_back('{1, 17'd65536,  17'd0,      0, none});
    rows.push_back('{1, 17'h1FFFF,  17'h1FFFF,  0, none});
    rows.push_back('{1, 17'd1,      17'h1FFFE,  0, none});
    rows.push_back('{2, 17'd0,      17'd0,      0, none});
    rows.push_back('{2, 17'h1FFFF,  17'd0,      0, none});
    rows.push_back('{2, 17'd0,      17'h1FFFF,  0, none});
    rows.push_back('{2, 17'h1FFFF,  17'h1FFFF,  0, none});
    rows.push_back('{2, 17'h0AAAA,  17'h15555,  0, none});
    // right terms cancel exactly at x = 0.5
    rows.push_back('{3, 17'd32768,  17'd12345,  1, zl_dir});
    rows.push_back('{3, 17'd32769,  17'd0,      0, none});
    rows.push_back('{3, 17'd0,      17'd0,      0, none});
    // a single nonzero lane rounds to +1.0 and saturates high
    rows.push_back('{4, 17'd0,      17'd0,      1,
                     '{dir_x: 16'sd32767, dir_y: 0, dir_z: 0, zero_length: 0}});
    rows.push_back('{4, 17'h1FFFF,  17'h1FFFF,  1,
                     '{dir_x: 16'sd32767, dir_y: 0, dir_z: 0, zero_length: 0}});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part, no idling
    cur_set = 0;
    foreach (rows[i]) begin
      if (rows[i].basis_set != cur_set) begin
        cur_set = rows[i].basis_set;
        load_basis(basis_sets[cur_set][0], basis_sets[cur_set][1],
                   basis_sets[cur_set][2]);
      end
      send_request(rows[i].image_x, rows[i].image_y, rows[i].typed, rows[i].want);
    end

    // random part: receiver-heavy idle, sender-heavy idle, then full rate
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 71 : 0;
      rx_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 19 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        if (blk == 3 && mode == 2) begin
          // range extremes once more, with unused top bit set in forward and right
          fv = pack_basis(TOP_N, TOP_P, TOP_N) | 64'h8000_0000_0000_0000;
          rv = pack_basis(TOP_P, TOP_N, TOP_P) | 64'h8000_0000_0000_0000;
          uv = pack_basis(TOP_N, TOP_N, TOP_P);
        end else begin
          fv = {1'($urandom), rand_comp(), rand_comp(), rand_comp()};
          rv = {1'($urandom), rand_comp(), rand_comp(), rand_comp()};
          uv = {1'($urandom), rand_comp(), rand_comp(), rand_comp()};
        end
        load_basis(fv, rv, uv);
        // the hold-off block offers more requests than the whole pipe holds
        n_items = (mode == 2 && blk == 1) ? 100 : 40;
        if (mode == 2 && blk == 1) hold_request = 1'b1;
        for (int n = 0; n < n_items; n++) begin
          // one pause until the pipe has fully emptied mid-stream
          if (mode == 2 && blk == 2 && n == 20) begin
            req_if.valid = 1'b0;
            while (expected_dirs.size() != 0) @(negedge clk);
          end
          send_request(rand_coord(), rand_coord(), 0, none);
        end
      end
    end

    drain_pipe();
    $display("sent %0d rays, checked %0d (%0d zero length), %0d basis writes",
             rays_sent, rays_checked, zero_rays, basis_writes);
    $display("covered reset basis, saturation, extremes and three stall profiles");
    if (mismatches == 0 && expected_dirs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cprd_pkg.sv
sv/cprd_in_if.sv
sv/cprd_out_if.sv
sv/cprd_regs.sv
sv/cprd_front.sv
sv/cprd_queue.sv
sv/cprd_back.sv
sv/camera_primary_ray_direction.sv
tb/sv/testbench.sv
